// ----- hdl/its_pkg.sv -----
// shared types, codes and constants for the indent token stream block
package its_pkg;

    // default sizes for the top level parameters
    localparam int STACK_DEPTH_DEF = 16;
    localparam int COLUMN_BITS_DEF = 10;

    // text codes
    localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] TAB_CHAR     = 8'h09;
    localparam int         TAB_STOP     = 8;

    // token kinds on the result stream
    typedef enum logic [2:0] {
        KIND_BLANK    = 3'd0,
        KIND_INDENT   = 3'd1,
        KIND_SAMEDENT = 3'd2,
        KIND_DEDENT   = 3'd3,
        KIND_DATA     = 3'd4,
        KIND_EOL      = 3'd5,
        KIND_END      = 3'd6,
        KIND_OVERFLOW = 3'd7
    } kind_t;

    // column counter operations
    typedef enum logic [1:0] {
        COL_HOLD  = 2'd0,
        COL_SPACE = 2'd1,
        COL_TAB   = 2'd2,
        COL_CLEAR = 2'd3
    } col_op_t;

    // level stack operations
    typedef enum logic [1:0] {
        STK_HOLD    = 2'd0,
        STK_POP     = 2'd1,
        STK_REPLACE = 2'd2,
        STK_PUSH    = 2'd3
    } stk_op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        col_op_t col_op;
        stk_op_t stk_op;
        logic    set_line;
        logic    emit;
        kind_t   kind;
        logic    last;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_eoi;
        logic is_newline;
        logic is_space;
        logic is_tab;
        logic in_line;
        logic out_free;
        logic can_pop;
        logic above_second;
        logic equal_top;
        logic full;
    } status_t;

endpackage

// ----- hdl/its_datapath.sv -----
// datapath: input word register, column counter, level stack and output register
module its_datapath #(
    parameter int STACK_DEPTH = its_pkg::STACK_DEPTH_DEF,
    parameter int COLUMN_BITS = its_pkg::COLUMN_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  its_pkg::cmd_t          cmd,
    output its_pkg::status_t       status,
    input  logic [7:0]             in_byte,
    input  logic                   in_eoi,
    input  logic                   out_ready,
    output logic                   out_valid,
    output its_pkg::kind_t         out_kind,
    output logic [7:0]             out_byte,
    output logic [COLUMN_BITS-1:0] out_level,
    output logic                   out_last
);

    localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEVEL_W = COLUMN_BITS + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] TAB_MASK = COLUMN_BITS'(its_pkg::TAB_STOP - 1);

    logic [7:0]             byte_reg;
    logic                   eoi_reg;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   line_reg, line_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic signed [LEVEL_W-1:0] lvl_reg [STACK_DEPTH];
    logic signed [LEVEL_W-1:0] indent;
    logic [COLUMN_BITS:0]   tab_sum;

    logic                   valid_reg;
    its_pkg::kind_t         kind_reg;
    logic [7:0]             obyte_reg, obyte_next;
    logic [COLUMN_BITS-1:0] olevel_reg;
    logic                   last_reg;

    // input word register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            eoi_reg  <= in_eoi;
        end
    end

    // current indent as a signed level
    assign indent  = $signed({1'b0, col_reg});
    assign tab_sum = {1'b0, col_reg | TAB_MASK} + (COLUMN_BITS + 1)'(1);

    // status toward the controller
    always_comb begin
        status.is_eoi       = eoi_reg;
        status.is_newline   = (byte_reg == its_pkg::NEWLINE_CHAR);
        status.is_space     = (byte_reg == its_pkg::SPACE_CHAR);
        status.is_tab       = (byte_reg == its_pkg::TAB_CHAR);
        status.in_line      = line_reg;
        status.out_free     = !valid_reg || out_ready;
        status.can_pop      = (ptr_reg != '0) && (indent < lvl_reg[0]);
        status.above_second = (indent > lvl_reg[1]);
        status.equal_top    = (indent == lvl_reg[0]);
        status.full         = (ptr_reg == PTR_W'(STACK_DEPTH - 1));
    end

    // column counter and line flag
    always_comb begin
        col_next  = col_reg;
        line_next = line_reg || cmd.set_line;
        case (cmd.col_op)
            its_pkg::COL_SPACE: begin
                if (col_reg != COL_MAX) begin
                    col_next = col_reg + COLUMN_BITS'(1);
                end
            end
            its_pkg::COL_TAB: begin
                col_next = tab_sum[COLUMN_BITS] ? COL_MAX : tab_sum[COLUMN_BITS-1:0];
            end
            its_pkg::COL_CLEAR: begin
                col_next  = '0;
                line_next = 1'b0;
            end
            default: begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    // level stack as a shift line, entry zero is the top
    always_comb begin
        case (cmd.stk_op)
            its_pkg::STK_POP:  ptr_next = ptr_reg - PTR_W'(1);
            its_pkg::STK_PUSH: ptr_next = ptr_reg + PTR_W'(1);
            default:           ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                lvl_reg[i] <= '1;
            end
        end else begin
            ptr_reg <= ptr_next;
            case (cmd.stk_op)
                its_pkg::STK_POP: begin
                    for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                        lvl_reg[i] <= lvl_reg[i+1];
                    end
                end
                its_pkg::STK_REPLACE: begin
                    lvl_reg[0] <= indent;
                end
                its_pkg::STK_PUSH: begin
                    for (int i = 1; i < STACK_DEPTH; i++) begin
                        lvl_reg[i] <= lvl_reg[i-1];
                    end
                    lvl_reg[0] <= indent;
                end
                default: begin
                    lvl_reg[0] <= lvl_reg[0];
                end
            endcase
        end
    end

    // data byte only rides on kinds that carry one
    always_comb begin
        case (cmd.kind) inside
            its_pkg::KIND_INDENT, its_pkg::KIND_SAMEDENT, its_pkg::KIND_DATA:
                obyte_next = byte_reg;
            default:
                obyte_next = 8'h00;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg   <= cmd.kind;
            obyte_reg  <= obyte_next;
            olevel_reg <= col_reg;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = obyte_reg;
    assign out_level = olevel_reg;
    assign out_last  = last_reg;

    // checks
    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!valid_reg || out_ready))
        else $error("word emitted over a stalled output word");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.stk_op == its_pkg::STK_POP) |-> (ptr_reg != '0))
        else $error("pop of the bottom level");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.stk_op == its_pkg::STK_PUSH) |-> (ptr_reg != PTR_W'(STACK_DEPTH - 1)))
        else $error("push onto a full level stack");

    a_dedent_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == its_pkg::KIND_DEDENT) |-> !last_reg)
        else $error("dedent closes a run");

endmodule

// ----- hdl/its_ctrl.sv -----
// controller: accepts a word, then steps it through the datapath
module its_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  its_pkg::status_t    status,
    output its_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_WORK   = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_ACCEPT);

    // command decode
    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.col_op   = its_pkg::COL_HOLD;
        cmd.stk_op   = its_pkg::STK_HOLD;
        cmd.set_line = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = its_pkg::KIND_BLANK;
        cmd.last     = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (status.is_eoi) begin
                    // end of stream, levels kept
                    if (status.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = its_pkg::KIND_END;
                        cmd.last   = 1'b1;
                        cmd.col_op = its_pkg::COL_CLEAR;
                        state_next = ST_ACCEPT;
                    end
                end else if (status.is_newline) begin
                    if (status.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = status.in_line ? its_pkg::KIND_EOL : its_pkg::KIND_BLANK;
                        cmd.last   = 1'b1;
                        cmd.col_op = its_pkg::COL_CLEAR;
                        state_next = ST_ACCEPT;
                    end
                end else if (status.in_line) begin
                    if (status.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = its_pkg::KIND_DATA;
                        cmd.last   = 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end else if (status.is_space) begin
                    cmd.col_op = its_pkg::COL_SPACE;
                    state_next = ST_ACCEPT;
                end else if (status.is_tab) begin
                    cmd.col_op = its_pkg::COL_TAB;
                    state_next = ST_ACCEPT;
                end else if (status.can_pop) begin
                    // one level per cycle, a pop only while the output is free: narrow dedent replaces, else pop
                    if (status.above_second) begin
                        cmd.stk_op = its_pkg::STK_REPLACE;
                    end else if (status.out_free) begin
                        cmd.stk_op = its_pkg::STK_POP;
                        cmd.emit   = 1'b1;
                        cmd.kind   = its_pkg::KIND_DEDENT;
                    end
                end else if (status.out_free) begin
                    // first data byte of the line
                    cmd.emit     = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.set_line = 1'b1;
                    state_next   = ST_ACCEPT;
                    if (status.equal_top) begin
                        cmd.kind = its_pkg::KIND_SAMEDENT;
                    end else if (!status.full) begin
                        cmd.kind   = its_pkg::KIND_INDENT;
                        cmd.stk_op = its_pkg::STK_PUSH;
                    end else begin
                        cmd.kind = its_pkg::KIND_OVERFLOW;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // checks
    a_load_only_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_WORK))
        else $error("loaded word not worked on");

    a_no_stack_op_outside_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCEPT) |-> (cmd.stk_op == its_pkg::STK_HOLD && !cmd.emit))
        else $error("stack or output touched while waiting for a word");

    a_last_leaves_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (state_reg == ST_ACCEPT))
        else $error("run closed but word still in work");

endmodule

// ----- hdl/indent_token_stream.sv -----
// top level of the indent token stream block
//
//  channel | dir | tdata (low bit up)                    | tuser      | tlast
//  s_      | in  | text_byte_in                          | -          | end_of_input
//  m_      | out | text_byte_out, indent_level, zero pad | token_kind | last_of_run
//
// an input word is accepted in ST_ACCEPT, then worked through in ST_WORK.
// a dedent pops or replaces one level per step, since the level stack moves
// by one entry per cycle; a pop waits while the output word is stalled.
// a stalled result holds the work cycle; the next word is accepted as soon as
// the last result of the current one sits in the output register.
// reset is synchronous, active low; the stack comes up holding only the bottom level.
module indent_token_stream #(
    parameter int STACK_DEPTH = its_pkg::STACK_DEPTH_DEF,
    parameter int COLUMN_BITS = its_pkg::COLUMN_BITS_DEF,
    localparam int TDATA_W    = ((8 + COLUMN_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // text_byte_in
    input  logic               s_tlast,   // end_of_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // text_byte_out, indent_level, zero pad
    output logic [2:0]         m_tuser,   // token_kind
    output logic               m_tlast    // last_of_run
);

    its_pkg::cmd_t          cmd;
    its_pkg::status_t       status;
    its_pkg::kind_t         out_kind;
    logic [7:0]             out_byte;
    logic [COLUMN_BITS-1:0] out_level;

    its_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    its_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .in_eoi    (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_level (out_level),
        .out_last  (m_tlast)
    );

    // pack result word
    assign m_tdata = TDATA_W'({out_level, out_byte});
    assign m_tuser = out_kind;

endmodule
